// ===== hw/rtl/pfa_pkg.sv =====
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int unsigned PAGE_SHIFT = 12;
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned OWNER_W    = 8;
    localparam int unsigned COUNT_W    = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    localparam logic [2:0] OP_ALLOC   = 3'd0;
    localparam logic [2:0] OP_ASSIGN  = 3'd1;
    localparam logic [2:0] OP_SHARE   = 3'd2;
    localparam logic [2:0] OP_RELEASE = 3'd3;
    localparam logic [2:0] OP_FREE    = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BUSY    = 2'd1;
    localparam logic [1:0] ST_BADADDR = 2'd2;

    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [COUNT_W-1:0] count;
    } t_entry;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_EXEC  = 4'b1000
    } t_state;

endpackage

// ===== hw/rtl/page_frame_allocator_refcount_top.sv =====
`timescale 1ns / 1ps

// Page frame allocator with per-frame owner and reference count.
// Input channel: i_in_valid / o_in_stall carries one operation per beat
// (opcode, byte address, new owner). Output channel: o_out_valid /
// i_out_stall returns exactly one result beat per operation, in order.
// Owner and count live in one single-port-write, registered-read memory
// of NUM_PAGES entries; each operation writes back at most one entry, after its reads.
// Non-alloc operations read their entry when the input beat is taken.
// Alloc scans the memory upwards from a lowest-free-page hint, one entry
// per cycle; when no free frame is known it answers busy without a scan;
// the hint moves to the frame above each allocation and drops to any
// freed frame below it.
// One operation is in flight at a time; the next input beat is taken once
// the result register is loaded.
// Reset: after i_rst_n the memory is cleared entry by entry, during which
// o_in_stall is high. The output valid flag is cleared.
// If the receiver stalls, the result holds in the output register and a
// finished operation waits before writing back, so nothing is lost.
module page_frame_allocator_refcount_top
    import pfa_pkg::*;
#(
    parameter int unsigned NUM_PAGES = 512
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [2:0]                i_opcode,
    input  logic [ADDR_W-1:0]         i_byte_address,
    input  logic signed [OWNER_W-1:0] i_new_owner,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [1:0]                o_status,
    output logic [ADDR_W-1:0]         o_page_address,
    output logic signed [OWNER_W-1:0] o_owner_out,
    output logic [COUNT_W-1:0]        o_count_out
);

    localparam int unsigned PW  = $clog2(NUM_PAGES);
    localparam int unsigned HW  = $clog2(NUM_PAGES + 1);
    localparam int unsigned PNW = ADDR_W - PAGE_SHIFT;
    localparam logic [PW-1:0]  LAST_PAGE = PW'(NUM_PAGES - 1);
    localparam logic [HW-1:0]  HINT_NONE = HW'(NUM_PAGES);
    localparam logic [PNW-1:0] PN_LIMIT  = PNW'(NUM_PAGES);

    t_entry              r_mem [NUM_PAGES];
    t_entry              r_rd;

    t_state              r_state, n_state;
    logic [2:0]          r_op, n_op;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [OWNER_W-1:0]  r_who, n_who;
    logic [PW-1:0]       r_pn, n_pn;
    logic                r_bad, n_bad;
    logic                r_none, n_none;
    logic [PW-1:0]       r_clr, n_clr;
    logic [PW-1:0]       r_scan, n_scan;
    logic [HW-1:0]       r_hint, n_hint;

    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_status, n_status;
    logic [ADDR_W-1:0]   r_page_addr, n_page_addr;
    logic [OWNER_W-1:0]  r_owner, n_owner;
    logic [COUNT_W-1:0]  r_count, n_count;

    logic                in_acc;
    logic                out_free;
    logic                in_bad;
    logic [PW-1:0]       in_pn;
    logic                rd_en;
    logic [PW-1:0]       rd_addr;
    logic                wr_en;
    logic [PW-1:0]       wr_addr;
    t_entry              wr_data;
    t_entry              nxt;
    logic                freed;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign in_pn    = i_byte_address[PAGE_SHIFT +: PW];
    assign in_bad   = (|i_byte_address[PAGE_SHIFT-1:0])
                   || (i_byte_address[ADDR_W-1:PAGE_SHIFT] >= PN_LIMIT);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_addr      = r_addr;
        n_who       = r_who;
        n_pn        = r_pn;
        n_bad       = r_bad;
        n_none      = r_none;
        n_clr       = r_clr;
        n_scan      = r_scan;
        n_hint      = r_hint;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_page_addr = r_page_addr;
        n_owner     = r_owner;
        n_count     = r_count;
        rd_en       = 1'b0;
        rd_addr     = r_scan;
        wr_en       = 1'b0;
        wr_addr     = r_pn;
        wr_data     = '0;
        nxt         = r_rd;
        freed       = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                n_clr   = r_clr + PW'(1);
                if (r_clr == LAST_PAGE) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_op   = i_opcode;
                    n_addr = i_byte_address;
                    n_who  = i_new_owner;
                    n_none = 1'b0;
                    if (i_opcode == OP_ALLOC) begin
                        n_bad = 1'b0;
                        if (r_hint == HINT_NONE) begin
                            n_none  = 1'b1;
                            n_state = S_EXEC;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_hint[PW-1:0];
                            n_scan  = r_hint[PW-1:0];
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_bad   = in_bad;
                        n_pn    = in_pn;
                        rd_en   = !in_bad;
                        rd_addr = in_pn;
                        n_state = S_EXEC;
                    end
                end
            end
            S_SCAN: begin
                if (r_rd.count == '0 && r_rd.owner == '0) begin
                    n_pn    = r_scan;
                    n_state = S_EXEC;
                end else if (r_scan == LAST_PAGE) begin
                    n_none  = 1'b1;
                    n_hint  = HINT_NONE;
                    n_state = S_EXEC;
                end else begin
                    n_scan  = r_scan + PW'(1);
                    rd_en   = 1'b1;
                    rd_addr = r_scan + PW'(1);
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    n_status    = ST_OK;
                    n_page_addr = r_addr;
                    if (r_bad) begin
                        n_status = ST_BADADDR;
                        nxt      = '0;
                    end else if (r_op == OP_ALLOC) begin
                        if (r_none) begin
                            n_status    = ST_BUSY;
                            n_page_addr = '0;
                            nxt         = '0;
                        end else begin
                            nxt.owner   = r_who;
                            nxt.count   = COUNT_W'(1);
                            wr_en       = 1'b1;
                            n_page_addr = ADDR_W'({r_pn, {PAGE_SHIFT{1'b0}}});
                            n_hint      = HW'(r_pn) + HW'(1);
                        end
                    end else begin
                        unique case (r_op)
                            OP_ASSIGN: begin
                                if (r_rd.count != '0) begin
                                    n_status = ST_BUSY;
                                end else begin
                                    nxt.owner = r_who;
                                    nxt.count = COUNT_W'(1);
                                    wr_en     = 1'b1;
                                end
                            end
                            OP_SHARE: begin
                                if (r_rd.count != COUNT_MAX) begin
                                    nxt.count = r_rd.count + COUNT_W'(1);
                                end
                                wr_en = 1'b1;
                            end
                            OP_RELEASE: begin
                                if (r_rd.count != '0) begin
                                    nxt.count = r_rd.count - COUNT_W'(1);
                                    if (r_rd.count == COUNT_W'(1)) begin
                                        nxt.owner = '0;
                                        freed     = 1'b1;
                                    end
                                end
                                wr_en = 1'b1;
                            end
                            OP_FREE: begin
                                nxt   = '0;
                                wr_en = 1'b1;
                                freed = 1'b1;
                            end
                            default: begin
                                nxt = r_rd;
                            end
                        endcase
                    end
                    wr_data = nxt;
                    n_owner = nxt.owner;
                    n_count = nxt.count;
                    if (freed && (HW'(r_pn) < r_hint)) begin
                        n_hint = HW'(r_pn);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_hint      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_hint      <= n_hint;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_addr      <= n_addr;
        r_who       <= n_who;
        r_pn        <= n_pn;
        r_bad       <= n_bad;
        r_none      <= n_none;
        r_scan      <= n_scan;
        r_status    <= n_status;
        r_page_addr <= n_page_addr;
        r_owner     <= n_owner;
        r_count     <= n_count;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_page_address = r_page_addr;
    assign o_owner_out    = r_owner;
    assign o_count_out    = r_count;

`ifndef SYNTHESIS
    a_clear_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_out_valid)
        else $error("result beat during clearing pass");

    a_accept_moves_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_SCAN || r_state == S_EXEC))
        else $error("accepted beat did not start work");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_BADADDR) |-> (o_owner_out == '0 && o_count_out == '0))
        else $error("bad address result carries owner or count");

    a_hint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hint <= HINT_NONE)
        else $error("free page hint out of range");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench
    import pfa_pkg::*;
();

    localparam int unsigned NUM_PAGES        = 512;
    localparam logic [31:0] PAGE_OFFSET_MASK = 32'h0000_0FFF;
    localparam int unsigned RESET_CYCLES     = 11;
    localparam int unsigned HOLD_CYCLES      = 300;
    localparam int unsigned DRAIN_CYCLES     = 20;
    localparam int unsigned CYCLE_LIMIT      = 4_000_000;

    localparam logic [2:0] OP_QUERY    = 3'd5;
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef enum int {
        MODE_NONE,
        MODE_SEND,
        MODE_RECV,
        MODE_BOTH,
        MODE_PRESSURE
    } t_mode;

    typedef struct {
        logic [2:0]         op;
        logic [31:0]        byte_addr;
        logic signed [7:0]  owner;
        t_mode              mode;
    } t_frame_op;

    typedef struct {
        logic [1:0]         status;
        logic [31:0]        page_addr;
        logic signed [7:0]  owner;
        logic [6:0]         count;
    } t_frame_report;

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      i_in_valid     = 1'b0;
    logic                      o_in_stall;
    logic [2:0]                i_opcode       = '0;
    logic [ADDR_W-1:0]         i_byte_address = '0;
    logic signed [OWNER_W-1:0] i_new_owner    = '0;
    logic                      o_out_valid;
    logic                      i_out_stall    = 1'b0;
    logic [1:0]                o_status;
    logic [ADDR_W-1:0]         o_page_address;
    logic signed [OWNER_W-1:0] o_owner_out;
    logic [COUNT_W-1:0]        o_count_out;

    logic signed [7:0] frame_owner [0:NUM_PAGES-1];
    logic [6:0]        frame_count [0:NUM_PAGES-1];

    t_frame_op     ops_to_send [$];
    t_frame_report reports_due [$];
    t_frame_op     next_op;
    t_frame_report arrived;
    t_mode         drive_mode   = MODE_NONE;
    int unsigned   rst_cycles   = 0;
    int unsigned   hold_cnt     = 0;
    bit            hold_done    = 1'b0;
    int unsigned   cycle_count  = 0;
    int unsigned   mismatches   = 0;

    page_frame_allocator_refcount_top #(
        .NUM_PAGES(NUM_PAGES)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_byte_address (i_byte_address),
        .i_new_owner    (i_new_owner),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_page_address (o_page_address),
        .o_owner_out    (o_owner_out),
        .o_count_out    (o_count_out)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (rst_cycles < RESET_CYCLES - 1) begin
            rst_cycles <= rst_cycles + 1;
        end else begin
            i_rst_n <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached", $time);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NUM_PAGES; i++) begin
            frame_owner[i] = '0;
            frame_count[i] = '0;
        end
    end

    function automatic t_frame_report apply_frame_op(logic [2:0] op, logic [31:0] a,
                                                     logic signed [7:0] w);
        t_frame_report r;
        int unsigned   pn;
        bit            found;
        r.status    = ST_OK;
        r.page_addr = a;
        r.owner     = '0;
        r.count     = '0;
        found       = 1'b0;
        if (op == OP_ALLOC) begin
            r.status    = ST_BUSY;
            r.page_addr = '0;
            for (int i = 0; i < NUM_PAGES && !found; i++) begin
                if (frame_count[i] == 0 && frame_owner[i] == 0) begin
                    frame_owner[i] = w;
                    frame_count[i] = 7'd1;
                    r.status       = ST_OK;
                    r.page_addr    = i << PAGE_SHIFT;
                    r.owner        = w;
                    r.count        = 7'd1;
                    found          = 1'b1;
                end
            end
            return r;
        end
        pn = a >> PAGE_SHIFT;
        if ((a & PAGE_OFFSET_MASK) != 0 || pn >= NUM_PAGES) begin
            r.status = ST_BADADDR;
            return r;
        end
        case (op)
            OP_ASSIGN: begin
                if (frame_count[pn] != 0) begin
                    r.status = ST_BUSY;
                end else begin
                    frame_owner[pn] = w;
                    frame_count[pn] = 7'd1;
                end
            end
            OP_SHARE: begin
                if (frame_count[pn] != COUNT_MAX) frame_count[pn] = frame_count[pn] + 7'd1;
            end
            OP_RELEASE: begin
                if (frame_count[pn] != 0) begin
                    frame_count[pn] = frame_count[pn] - 7'd1;
                    if (frame_count[pn] == 0) frame_owner[pn] = '0;
                end
            end
            OP_FREE: begin
                frame_count[pn] = '0;
                frame_owner[pn] = '0;
            end
            default: ;
        endcase
        r.owner = frame_owner[pn];
        r.count = frame_count[pn];
        return r;
    endfunction

    function automatic int unsigned send_idle_pct(t_mode m);
        if (m == MODE_SEND) return 55;
        if (m == MODE_BOTH) return 8;
        return 0;
    endfunction

    function automatic int unsigned recv_stall_pct(t_mode m);
        if (m == MODE_RECV) return 55;
        if (m == MODE_BOTH) return 8;
        return 0;
    endfunction

    function automatic logic [31:0] pick_address();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 75) return $urandom_range(15) << PAGE_SHIFT;
        if (r < 85) return $urandom_range(NUM_PAGES - 1) << PAGE_SHIFT;
        if (r < 90) return ($urandom_range(NUM_PAGES - 1) << PAGE_SHIFT) | $urandom_range(4095, 1);
        if (r < 95) return $urandom_range(32'h000F_FFFF, NUM_PAGES) << PAGE_SHIFT;
        return $urandom;
    endfunction

    function automatic logic [2:0] pick_opcode();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20) return OP_ALLOC;
        if (r < 35) return OP_ASSIGN;
        if (r < 55) return OP_SHARE;
        if (r < 75) return OP_RELEASE;
        if (r < 85) return OP_FREE;
        if (r < 95) return OP_QUERY;
        return 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    endfunction

    task automatic push_op(logic [2:0] op, logic [31:0] a, logic signed [7:0] w, t_mode m);
        t_frame_op item;
        item.op        = op;
        item.byte_addr = a;
        item.owner     = w;
        item.mode      = m;
        ops_to_send.push_back(item);
    endtask

    task automatic push_random(int unsigned n, t_mode m);
        for (int i = 0; i < n; i++) push_op(pick_opcode(), pick_address(), 8'($urandom), m);
    endtask

    // driver: a beat holds while stalled, a new one is taken only after acceptance
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_stall === 1'b0) begin
                reports_due.push_back(apply_frame_op(i_opcode, i_byte_address, i_new_owner));
            end
            if (!i_in_valid || o_in_stall === 1'b0) begin
                if (ops_to_send.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct(ops_to_send[0].mode)) begin
                    next_op = ops_to_send.pop_front();
                    i_in_valid     <= 1'b1;
                    i_opcode       <= next_op.op;
                    i_byte_address <= next_op.byte_addr;
                    i_new_owner    <= next_op.owner;
                    drive_mode     <= next_op.mode;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_field(string name, logic [31:0] exp, logic [31:0] act);
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp, act);
        mismatches++;
    endtask

    // monitor
    always @(posedge i_clk) begin
        if (o_out_valid === 1'b1 && !i_out_stall) begin
            if (reports_due.size() == 0) begin
                $display("%0t: result beat with nothing expected, status %0h address %0h",
                         $time, o_status, o_page_address);
                mismatches++;
            end else begin
                arrived = reports_due.pop_front();
                if (o_status !== arrived.status)
                    report_field("status", 32'(arrived.status), 32'(o_status));
                if (o_page_address !== arrived.page_addr)
                    report_field("page_address", arrived.page_addr, o_page_address);
                if (o_owner_out !== arrived.owner)
                    report_field("owner_out", 32'(arrived.owner), 32'(o_owner_out));
                if (o_count_out !== arrived.count)
                    report_field("count_out", 32'(arrived.count), 32'(o_count_out));
            end
        end
        if (drive_mode == MODE_PRESSURE && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_cnt    <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct(drive_mode));
        end
    end

    initial begin
        // directed
        push_op(OP_ALLOC,   32'h0000_0000, 8'sd5,    MODE_NONE);
        push_op(OP_ALLOC,   32'h0000_0000, -8'sd2,   MODE_NONE);
        push_op(OP_ALLOC,   32'hFFFF_FFFF, 8'sd127,  MODE_NONE);
        push_op(OP_ALLOC,   32'h0000_0000, -8'sd128, MODE_NONE);
        push_op(OP_QUERY,   32'h0000_0000, 8'sd0,    MODE_NONE);
        push_op(OP_SHARE,   32'h0000_0000, 8'sd0,    MODE_NONE);
        push_op(OP_RELEASE, 32'h0000_1000, 8'sd0,    MODE_NONE);
        push_op(OP_RELEASE, 32'h0000_1000, 8'sd0,    MODE_NONE);
        push_op(OP_ASSIGN,  32'h0000_1000, -8'sd1,   MODE_NONE);
        push_op(OP_ASSIGN,  32'h0000_1000, 8'sd3,    MODE_NONE);
        push_op(OP_ASSIGN,  32'h0000_1001, 8'sd3,    MODE_NONE);
        push_op(OP_ASSIGN,  32'h0020_0000, 8'sd3,    MODE_NONE);
        push_op(OP_SHARE,   32'hFFFF_F000, 8'sd0,    MODE_NONE);
        push_op(OP_QUERY,   32'hFFFF_FFFF, 8'sd0,    MODE_NONE);
        push_op(OP_RELEASE, 32'h0000_0800, 8'sd0,    MODE_NONE);
        push_op(OP_FREE,    32'h0000_0000, 8'sd0,    MODE_NONE);
        push_op(OP_FREE,    32'h0000_0000, 8'sd0,    MODE_NONE);
        push_op(OP_SHARE,   32'h0000_4000, 8'sd0,    MODE_NONE);
        push_op(OP_ASSIGN,  32'h001F_F000, 8'sd127,  MODE_NONE);
        push_op(OP_ASSIGN,  32'h0000_6000, 8'sd0,    MODE_NONE);
        push_op(OP_ALLOC,   32'h0000_0000, 8'sd0,    MODE_NONE);
        push_op(OP_SPARE_LO, 32'h0000_1000, 8'sd0,   MODE_NONE);
        push_op(OP_SPARE_HI, 32'h001F_F000, 8'sd0,   MODE_NONE);
        push_op(OP_FREE,    32'h001F_F000, 8'sd0,    MODE_NONE);

        // count saturation on one frame
        push_op(OP_FREE, 32'h0000_5000, 8'sd0, MODE_NONE);
        for (int i = 0; i < 130; i++) push_op(OP_SHARE, 32'h0000_5000, 8'sd0, MODE_NONE);
        push_op(OP_RELEASE, 32'h0000_5000, 8'sd0, MODE_NONE);

        push_random(60,  MODE_NONE);
        push_random(170, MODE_SEND);
        push_random(170, MODE_RECV);
        push_random(170, MODE_BOTH);
        push_random(60,  MODE_PRESSURE);

        // exhaust the frame store, then churn near the bottom
        for (int i = 0; i < 520; i++) push_op(OP_ALLOC, $urandom, 8'($urandom), MODE_SEND);
        push_random(50, MODE_RECV);

        while (ops_to_send.size() != 0 || i_in_valid !== 1'b0) @(posedge i_clk);
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (reports_due.size() != 0) begin
            $display("%0t: %0d result beats never arrived", $time, reports_due.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
